>>> design/smsi_pkg.sv
// ----------------------------------------------------------------------------
// smsi_pkg
// Shared types, sizes and codes for the sorted monomial set insert unit.
// ----------------------------------------------------------------------------
package smsi_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int MAX_VARS    = 8;
    localparam int EXP_BITS    = 8;

    localparam int VEC_W  = 64;
    localparam int DEG_W  = 11;
    localparam int POS_W  = 8;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int NV_W   = $clog2(MAX_VARS + 1);
    localparam int LVLS   = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_READ_OK   = 3'd5,
        ST_BAD_POS   = 3'd6,
        ST_CLEARED   = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        ORD_GREVLEX = 2'd0,
        ORD_GRLEX   = 2'd1,
        ORD_LEX     = 2'd2,
        ORD_LEX_ALT = 2'd3
    } t_order;

    typedef enum logic {
        CFG_ORDER_MODE  = 1'b0,
        CFG_ACTIVE_VARS = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EVAL  = 2'd1,
        S_APPLY = 2'd2
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [VEC_W-1:0]  vec;
        logic [DEG_W-1:0]  deg;
        logic [POS_W-1:0]  pos;
    } t_item;

    // item and order settings seen by every cell
    typedef struct packed {
        logic [VEC_W-1:0]  vec;
        logic [DEG_W-1:0]  deg;
        t_order            mode;
        logic [NV_W-1:0]   nvars;
    } t_bcast;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic above;
        logic equal;
        logic exact;
    } t_cell_flags;

endpackage

>>> design/smsi_cell.sv
// ----------------------------------------------------------------------------
// smsi_cell
// One table slot: holds an entry, ranks the broadcast item against it and
// takes its left neighbour's entry when the row shifts on an insert.
// ----------------------------------------------------------------------------
module smsi_cell (
    input  logic                     i_clk,
    input  smsi_pkg::t_bcast         i_bcast,
    input  smsi_pkg::t_cell_ctl      i_ctl,
    input  logic [63:0]              i_prev_vec,
    input  logic [10:0]              i_prev_deg,
    output logic [63:0]              o_vec,
    output logic [10:0]              o_deg,
    output smsi_pkg::t_cell_flags    o_flags
);
    import smsi_pkg::*;

    logic [VEC_W-1:0] r_vec;
    logic [DEG_W-1:0] r_deg;
    logic [MAX_VARS-1:0] gt;
    logic [MAX_VARS-1:0] lt;
    logic lex_above, lex_below, rev_above, rev_below;
    logic deg_gt, deg_lt, use_deg, above, below;
    logic [EXP_BITS-1:0] ea, eb;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_vec <= i_bcast.vec;
            r_deg <= i_bcast.deg;
        end else if (i_ctl.shift) begin
            r_vec <= i_prev_vec;
            r_deg <= i_prev_deg;
        end
    end

    always_comb begin
        gt = '0;
        lt = '0;
        for (int v = 0; v < MAX_VARS; v++) begin
            ea = i_bcast.vec[v*EXP_BITS +: EXP_BITS];
            eb = r_vec[v*EXP_BITS +: EXP_BITS];
            if (NV_W'(v) < i_bcast.nvars) begin
                gt[v] = ea > eb;
                lt[v] = ea < eb;
            end
        end
        // lowest differing variable decides for lex / grlex
        lex_above = 1'b0;
        lex_below = 1'b0;
        for (int v = MAX_VARS - 1; v >= 0; v--) begin
            if (gt[v] || lt[v]) begin
                lex_above = gt[v];
                lex_below = lt[v];
            end
        end
        // highest differing variable decides for grevlex, smaller ranks first
        rev_above = 1'b0;
        rev_below = 1'b0;
        for (int v = 0; v < MAX_VARS; v++) begin
            if (gt[v] || lt[v]) begin
                rev_above = lt[v];
                rev_below = gt[v];
            end
        end
        deg_gt  = i_bcast.deg > r_deg;
        deg_lt  = i_bcast.deg < r_deg;
        use_deg = (i_bcast.mode == ORD_GREVLEX) || (i_bcast.mode == ORD_GRLEX);
        if (use_deg && (deg_gt || deg_lt)) begin
            above = deg_gt;
            below = deg_lt;
        end else if (i_bcast.mode == ORD_GREVLEX) begin
            above = rev_above;
            below = rev_below;
        end else begin
            above = lex_above;
            below = lex_below;
        end
        o_flags.above = above;
        o_flags.equal = !above && !below;
        o_flags.exact = (i_bcast.deg == r_deg) && ((gt | lt) == '0);
    end

    assign o_vec = r_vec;
    assign o_deg = r_deg;

endmodule

>>> design/sorted_monomial_set_insert_unit.sv
// ----------------------------------------------------------------------------
// sorted_monomial_set_insert_unit
// Sorted, duplicate-free monomial table built as a shifting row of cells.
// ----------------------------------------------------------------------------
// One command is handled at a time: the input stalls until it is through the
// evaluate and apply states and its result is registered. In the evaluate
// state every cell ranks the registered item against its own entry in
// parallel. In the apply state the first hit along the row is encoded and the
// row shifts right of the insertion point in a single step. The result sits in
// an output register, so the next command is taken while it waits. That
// command then holds in its apply state until the waiting result is taken.
// Clear only resets the fill count; no sweep of the cells is needed and the
// unit is ready straight out of reset. Configuration writes are accepted in
// any cycle.
module sorted_monomial_set_insert_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_exponent_vector,
    input  logic [10:0] i_total_degree,
    input  logic [7:0]  i_position,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_result_position,
    output logic [8:0]  o_entry_count_out,
    output logic [63:0] o_exponent_vector_out,
    output logic [10:0] o_degree_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    import smsi_pkg::*;

    t_state r_state, n_state;
    t_item  r_item;
    t_order r_order_mode;
    logic [3:0] r_active_vars;
    logic [CNT_W-1:0] r_count, n_count;
    t_bcast bcast;

    logic [TABLE_DEPTH-1:0] r_above, r_equal, r_exact;
    logic [TABLE_DEPTH-1:0] live, hit, pre, first, xpre, xfirst;
    logic [VEC_W-1:0] cell_vec [TABLE_DEPTH];
    logic [DEG_W-1:0] cell_deg [TABLE_DEPTH];
    t_cell_flags      flags    [TABLE_DEPTH];
    t_cell_ctl        ctl      [TABLE_DEPTH];

    logic [IDX_W-1:0] place, xidx, ridx;
    logic any_hit, any_x, is_dup, apply, out_free;
    logic [2:0] res_status;
    logic [POS_W-1:0] res_pos;
    logic [VEC_W-1:0] res_vec;
    logic [DEG_W-1:0] res_deg;

    logic r_out_valid;
    logic [2:0] r_status;
    logic [POS_W-1:0] r_rpos;
    logic [CNT_W-1:0] r_cnt_out;
    logic [VEC_W-1:0] r_vout;
    logic [DEG_W-1:0] r_dout;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode  <= ORD_GREVLEX;
            r_active_vars <= 4'(MAX_VARS);
        end else if (i_cfg_valid && i_cfg_index[1] == 1'b0) begin
            unique case (t_cfg_reg'(i_cfg_index[0]))
                CFG_ORDER_MODE:  r_order_mode  <= t_order'(i_cfg_data[1:0]);
                CFG_ACTIVE_VARS: r_active_vars <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign bcast.vec   = r_item.vec;
    assign bcast.deg   = r_item.deg;
    assign bcast.mode  = r_order_mode;
    assign bcast.nvars = (r_active_vars > 4'(MAX_VARS)) ? NV_W'(MAX_VARS)
                                                         : NV_W'(r_active_vars);

    // ---- control ----
    assign out_free   = !r_out_valid || !i_out_stall;
    assign apply      = (r_state == S_APPLY) && out_free;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EVAL;
            S_EVAL:  n_state = S_APPLY;
            S_APPLY: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item.cmd <= t_cmd'(i_command);
            r_item.vec <= i_exponent_vector;
            r_item.deg <= i_total_degree;
            r_item.pos <= i_position;
        end
    end

    // ---- row of cells ----
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            smsi_cell u_cell (
                .i_clk     (i_clk),
                .i_bcast   (bcast),
                .i_ctl     (ctl[g]),
                .i_prev_vec(r_item.vec),
                .i_prev_deg(r_item.deg),
                .o_vec     (cell_vec[g]),
                .o_deg     (cell_deg[g]),
                .o_flags   (flags[g])
            );
        end else begin : g_body
            smsi_cell u_cell (
                .i_clk     (i_clk),
                .i_bcast   (bcast),
                .i_ctl     (ctl[g]),
                .i_prev_vec(cell_vec[g-1]),
                .i_prev_deg(cell_deg[g-1]),
                .o_vec     (cell_vec[g]),
                .o_deg     (cell_deg[g]),
                .o_flags   (flags[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_above[i] <= flags[i].above;
                r_equal[i] <= flags[i].equal;
                r_exact[i] <= flags[i].exact;
            end
        end
    end

    // first hit along the row via a log-depth prefix OR
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            live[i] = CNT_W'(i) < r_count;
        hit  = (r_above | r_equal) & live;
        pre  = hit;
        xpre = r_exact & live;
        for (int l = 0; l < LVLS; l++) begin
            pre  = pre  | (pre  << (1 << l));
            xpre = xpre | (xpre << (1 << l));
        end
        first  = hit & ~(pre << 1);
        xfirst = r_exact & live & ~(xpre << 1);
        any_hit = |hit;
        any_x   = |xfirst;
        xidx  = '0;
        place = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (first[i])  place = place | IDX_W'(i);
            if (xfirst[i]) xidx  = xidx  | IDX_W'(i);
        end
        if (!any_hit) place = IDX_W'(r_count);
        is_dup = |(first & r_equal);
    end

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ctl[i].shift = 1'b0;
            ctl[i].load  = 1'b0;
        end
        if (apply && r_item.cmd == CMD_INSERT && !is_dup
            && r_count != CNT_W'(TABLE_DEPTH)) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                ctl[i].shift = (pre[i] & ~first[i]);
                ctl[i].load  = any_hit ? first[i] : (CNT_W'(i) == r_count);
            end
        end
    end

    // ---- result ----
    always_comb begin
        ridx       = IDX_W'(r_item.pos);
        res_status = ST_CLEARED;
        res_pos    = '0;
        res_vec    = '0;
        res_deg    = '0;
        n_count    = r_count;
        case (r_item.cmd)
            CMD_INSERT: begin
                if (is_dup) begin
                    res_status = ST_DUPLICATE;
                    res_pos    = POS_W'(place);
                end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    res_status = ST_FULL;
                end else begin
                    res_status = ST_INSERTED;
                    res_pos    = POS_W'(place);
                    n_count    = r_count + 1'b1;
                end
            end
            CMD_LOOKUP: begin
                res_status = any_x ? ST_FOUND : ST_NOT_FOUND;
                res_pos    = any_x ? POS_W'(xidx) : '0;
            end
            CMD_READ: begin
                if ({1'b0, r_item.pos} < (POS_W+1)'(r_count)) begin
                    res_status = ST_READ_OK;
                    res_pos    = r_item.pos;
                    res_vec    = cell_vec[ridx];
                    res_deg    = cell_deg[ridx];
                end else begin
                    res_status = ST_BAD_POS;
                end
            end
            default: begin
                res_status = ST_CLEARED;
                n_count    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply) begin
            r_status  <= res_status;
            r_rpos    <= res_pos;
            r_cnt_out <= n_count;
            r_vout    <= res_vec;
            r_dout    <= res_deg;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_status;
    assign o_result_position     = r_rpos;
    assign o_entry_count_out     = 9'(r_cnt_out);
    assign o_exponent_vector_out = r_vout;
    assign o_degree_out          = r_dout;

endmodule

>>> design/smsi_checker.sv
// ----------------------------------------------------------------------------
// smsi_checker
// Port-level checks on the result channel of the monomial table.
// ----------------------------------------------------------------------------
module smsi_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  o_status,
    input  logic [7:0]  o_result_position,
    input  logic [8:0]  o_entry_count_out,
    input  logic [63:0] o_exponent_vector_out,
    input  logic [10:0] o_degree_out
);
    import smsi_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_entry_count_out))
        else $error("result changed while stalled");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_CLEARED |-> o_entry_count_out == '0)
        else $error("clear left entries");

    a_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_READ_OK
            |-> o_exponent_vector_out == '0 && o_degree_out == '0)
        else $error("entry data on a non-read result");

    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_INSERTED || o_status == ST_FOUND
            || o_status == ST_READ_OK || o_status == ST_DUPLICATE)
            |-> {1'b0, o_result_position} < o_entry_count_out)
        else $error("position beyond held entries");

endmodule

bind sorted_monomial_set_insert_unit smsi_checker u_smsi_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_status             (o_status),
    .o_result_position    (o_result_position),
    .o_entry_count_out    (o_entry_count_out),
    .o_exponent_vector_out(o_exponent_vector_out),
    .o_degree_out         (o_degree_out)
);
